/* rtl/mbps_pkg.sv */
// shared types and constants for the masked byte pattern scan unit
// no dependencies; imported by every module of the block
package mbps_pkg;

   localparam int LANE_BITS     = 8;
   localparam int PATTERN_SLOTS = 16;
   localparam int SLOT_BITS     = $clog2(PATTERN_SLOTS);
   localparam int LENGTH_BITS   = 5;
   localparam int WORD_BITS     = 64;
   localparam int ADDR_BITS     = 64;
   localparam int CSR_INDEX_BITS = 3;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [LANE_BITS-1:0] BYTE_MASK = 8'hff;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PATTERN_LOW    = 3'd0,
      CSR_PATTERN_HIGH   = 3'd1,
      CSR_MASK_LOW       = 3'd2,
      CSR_MASK_HIGH      = 3'd3,
      CSR_PATTERN_LENGTH = 3'd4,
      CSR_REGION_BASE    = 3'd5
   } csr_index_type;

   typedef logic [LANE_BITS-1:0] lane_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

/* rtl/mbps_front.sv */
// front end: byte window, masked compare and first-match tracking per region
// depends on mbps_pkg; pushes one record per region into mbps_queue
module mbps_front #(
   parameter int MAX_PATTERN_BYTES = 16,
   parameter int OFFSET_BITS       = 32
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   input  logic [7:0]                                 req_tdata,   // data_byte
   input  logic                                       req_tlast,   // is_last
   input  logic [2*mbps_pkg::WORD_BITS-1:0]           pattern,
   input  logic [2*mbps_pkg::WORD_BITS-1:0]           mask,
   input  logic [mbps_pkg::LENGTH_BITS-1:0]           pattern_length,
   input  mbps_pkg::queue_status_type                 q_status,
   output logic                                       push,
   output logic [OFFSET_BITS:0]                       push_data   // offset, found on top
);
   import mbps_pkg::*;

   localparam logic [LENGTH_BITS-1:0] MAX_LEN = LENGTH_BITS'(MAX_PATTERN_BYTES);

   lane_type                window_ff [MAX_PATTERN_BYTES];
   lane_type                window_in [MAX_PATTERN_BYTES];
   logic [OFFSET_BITS-1:0]  count_ff, count_in;
   logic                    seen_ff, seen_in;
   logic [OFFSET_BITS-1:0]  offset_ff, offset_in;

   lane_type                pat_lane [PATTERN_SLOTS];
   lane_type                msk_lane [PATTERN_SLOTS];
   lane_type                shifted [MAX_PATTERN_BYTES];
   logic [MAX_PATTERN_BYTES-1:0] lane_ok;
   logic                    accept;
   logic                    advanced;
   logic [OFFSET_BITS-1:0]  count_next;
   logic [OFFSET_BITS-1:0]  len_wide;
   logic                    len_ok;
   logic                    hit;
   logic                    found_now;
   logic [OFFSET_BITS-1:0]  offset_now;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      for (int i = 0; i < PATTERN_SLOTS; i++) begin
         pat_lane[i] = pattern[i*LANE_BITS +: LANE_BITS];
         msk_lane[i] = mask[i*LANE_BITS +: LANE_BITS];
      end
   end

   // window after taking the new byte, newest at entry 0
   always_comb begin
      shifted[0] = req_tdata & BYTE_MASK;
      for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
         shifted[k] = window_ff[k-1];
      end
   end

   // window entry j lines up with pattern byte length-1-j
   always_comb begin
      logic [LENGTH_BITS-1:0] idx;
      for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
         idx = pattern_length - LENGTH_BITS'(j) - LENGTH_BITS'(1);
         if (LENGTH_BITS'(j) < pattern_length) begin
            lane_ok[j] = (shifted[j] & msk_lane[idx[SLOT_BITS-1:0]]) ==
                         (pat_lane[idx[SLOT_BITS-1:0]] & msk_lane[idx[SLOT_BITS-1:0]]);
         end else begin
            lane_ok[j] = 1'b1;
         end
      end
   end

   assign advanced   = (count_ff != '1);
   assign count_next = advanced ? count_ff + OFFSET_BITS'(1) : count_ff;
   assign len_wide   = OFFSET_BITS'(pattern_length);
   assign len_ok     = (pattern_length != '0) && (pattern_length <= MAX_LEN);
   assign hit        = !seen_ff && advanced && len_ok && (count_next >= len_wide) &&
                       (&lane_ok);
   assign found_now  = seen_ff || hit;
   assign offset_now = hit ? count_next - len_wide : offset_ff;

   assign push      = accept && req_tlast;
   assign push_data = {found_now, offset_now};

   always_comb begin
      window_in = window_ff;
      count_in  = count_ff;
      seen_in   = seen_ff;
      offset_in = offset_ff;
      if (accept) begin
         if (req_tlast) begin
            for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
               window_in[k] = '0;
            end
            count_in  = '0;
            seen_in   = 1'b0;
            offset_in = '0;
         end else begin
            window_in = shifted;
            count_in  = count_next;
            seen_in   = found_now;
            offset_in = offset_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
            window_ff[k] <= '0;
         end
         count_ff  <= '0;
         seen_ff   <= 1'b0;
         offset_ff <= '0;
      end else begin
         window_ff <= window_in;
         count_ff  <= count_in;
         seen_ff   <= seen_in;
         offset_ff <= offset_in;
      end
   end

endmodule

/* rtl/mbps_queue.sv */
// short fifo of per-region records between front end and result stage
// depends on mbps_pkg for depth and status struct
module mbps_queue #(
   parameter int WIDTH = 33
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output mbps_pkg::queue_status_type status
);
   import mbps_pkg::*;

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(QUEUE_DEPTH);

   logic [WIDTH-1:0]    entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == FULL_CNT);
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/mbps_back.sv */
// result stage: adds region base to match offset and holds the output register
// depends on mbps_pkg; drains records from mbps_queue
module mbps_back #(
   parameter int OFFSET_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [mbps_pkg::ADDR_BITS-1:0]    region_base,
   input  mbps_pkg::queue_status_type        q_status,
   input  logic [OFFSET_BITS:0]              q_data,     // offset, found on top
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [63:0]                       rsp_tdata,  // match_address
   output logic                              rsp_tuser   // found
);
   import mbps_pkg::*;

   logic                 valid_ff, valid_in;
   logic                 found_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic                 rec_found;
   logic [ADDR_BITS-1:0] rec_addr;

   assign rec_found = q_data[OFFSET_BITS];
   assign rec_addr  = rec_found ?
                      region_base + ADDR_BITS'(q_data[OFFSET_BITS-1:0]) : '0;

   assign pop      = !q_status.empty && (!valid_ff || rsp_tready);
   assign valid_in = pop ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (pop) begin
         found_ff <= rec_found;
         addr_ff  <= rec_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = addr_ff;
   assign rsp_tuser  = found_ff;

endmodule

/* rtl/masked_byte_pattern_scan_unit.sv */
// top level of the masked byte pattern scan unit: register file and wiring
// depends on mbps_pkg, mbps_front, mbps_queue and mbps_back
//
// The req channel carries a memory region one byte per transaction, with
// req_tlast on its final byte. The unit compares the newest pattern_length
// bytes against the configured pattern under a per-byte mask (mask byte of
// zero = wildcard) after every byte and keeps the first matching offset.
// For each region one transaction leaves on rsp: rsp_tuser is the found flag,
// rsp_tdata is region_base plus the first match offset (zero if not found).
// Throughput: one byte per cycle while the queue is not full, set by the window
// shift and parallel compare in the front end. The edge that takes the last byte
// of a region writes its record into the queue, from which it is then loaded
// into the result register that drives rsp_tvalid, rsp_tdata and rsp_tuser.
// A stalled rsp side fills the two-entry queue; req_tready drops only when
// the queue is full, so bytes of the next region keep flowing meanwhile.
// Reset clears the window, counters and queue, and loads the registers with
// pattern zero, masks all ones, length zero and base zero. csr writes take
// effect at the next edge and are meant for idle periods only.
module masked_byte_pattern_scan_unit #(
   parameter int MAX_PATTERN_BYTES = 16,
   parameter int OFFSET_BITS       = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,   // [7:0] data_byte
   input  logic                                  req_tlast,   // is_last
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [63:0]                           rsp_tdata,   // [63:0] match_address
   output logic                                  rsp_tuser,   // found
   input  logic                                  csr_wen,
   input  logic [mbps_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [mbps_pkg::WORD_BITS-1:0]        csr_wdata
);
   import mbps_pkg::*;

   logic [WORD_BITS-1:0]   pattern_low_ff, pattern_high_ff;
   logic [WORD_BITS-1:0]   mask_low_ff, mask_high_ff;
   logic [LENGTH_BITS-1:0] length_ff;
   logic [ADDR_BITS-1:0]   base_ff;

   queue_status_type       q_status;
   logic                   push, pop;
   logic [OFFSET_BITS:0]   push_data, pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         mask_low_ff     <= '1;
         mask_high_ff    <= '1;
         length_ff       <= '0;
         base_ff         <= '0;
      end else if (csr_wen) begin
         case (csr_index_type'(csr_index))
            CSR_PATTERN_LOW:    pattern_low_ff  <= csr_wdata;
            CSR_PATTERN_HIGH:   pattern_high_ff <= csr_wdata;
            CSR_MASK_LOW:       mask_low_ff     <= csr_wdata;
            CSR_MASK_HIGH:      mask_high_ff    <= csr_wdata;
            CSR_PATTERN_LENGTH: length_ff       <= csr_wdata[LENGTH_BITS-1:0];
            CSR_REGION_BASE:    base_ff         <= csr_wdata;
            default: ;
         endcase
      end
   end

   mbps_front #(
      .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
      .OFFSET_BITS       (OFFSET_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .pattern        ({pattern_high_ff, pattern_low_ff}),
      .mask           ({mask_high_ff, mask_low_ff}),
      .pattern_length (length_ff),
      .q_status       (q_status),
      .push           (push),
      .push_data      (push_data)
   );

   mbps_queue #(
      .WIDTH (OFFSET_BITS + 1)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   mbps_back #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .region_base (base_ff),
      .q_status    (q_status),
      .q_data      (pop_data),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

/* sim/tb_masked_byte_pattern_scan_unit.sv */
// testbench for masked_byte_pattern_scan_unit: regions of bytes in, one scan result per region out
// predicts window matches itself and checks every rsp transaction in order
// depends on mbps_pkg and the rtl of the unit
`timescale 1ns / 100ps

module tb_masked_byte_pattern_scan_unit;
   import mbps_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1300;
   localparam int PHASE_ITEMS  = 120;
   localparam int IDLE_NONE    = 0;
   localparam int IDLE_FULL    = 1;
   localparam int IDLE_SPARSE  = 2;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } region_byte_type;

   typedef struct packed {
      logic        found;
      logic [63:0] address;
   } scan_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] data_byte
   logic req_tlast = 1'b0;          // is_last
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;          // [63:0] match_address
   logic rsp_tuser;                 // found
   logic csr_wen = 1'b0;
   csr_index_type csr_index = CSR_PATTERN_LOW;
   logic [WORD_BITS-1:0] csr_wdata = '0;

   masked_byte_pattern_scan_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // register copies and scan state of the predictor
   logic [63:0] cfg_pattern_lo = '0;
   logic [63:0] cfg_pattern_hi = '0;
   logic [63:0] cfg_mask_lo = '1;
   logic [63:0] cfg_mask_hi = '1;
   logic [4:0]  cfg_length = '0;
   logic [63:0] cfg_base = '0;
   logic [7:0]  scan_window [16];
   logic [31:0] bytes_taken = '0;
   logic        hit_seen = 1'b0;
   logic [31:0] hit_offset = '0;

   region_byte_type region_bytes_q [$];
   scan_result_type pending_matches [$];

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned random_items = 0;
   int unsigned req_gap = 0;
   int unsigned rsp_wait = 0;
   int unsigned hold_goal = 0;
   int unsigned hold_done = 0;
   int req_idle_mode = IDLE_NONE;
   int rsp_idle_mode = IDLE_NONE;
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;

   initial begin
      for (int k = 0; k < 16; k++) scan_window[k] = 8'h00;
   end

   function automatic logic [7:0] lane_of(logic [63:0] lo, logic [63:0] hi, int i);
      logic [63:0] w;
      w = (i < 8) ? lo : hi;
      return w[8 * (i % 8) +: 8];
   endfunction

   function automatic bit window_hits(int unsigned len);
      logic [7:0] m;
      for (int i = 0; i < len; i++) begin
         m = lane_of(cfg_mask_lo, cfg_mask_hi, i);
         if ((scan_window[len - 1 - i] & m) != (lane_of(cfg_pattern_lo, cfg_pattern_hi, i) & m))
            return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void track_byte(logic [7:0] data, logic last);
      scan_result_type r;
      bit advanced;
      int unsigned len;
      len = cfg_length;
      for (int k = 15; k > 0; k--) scan_window[k] = scan_window[k - 1];
      scan_window[0] = data;
      advanced = (bytes_taken != 32'hffff_ffff);
      if (advanced) bytes_taken = bytes_taken + 1;
      // a window completing while the counter is stuck has no known offset
      if (!hit_seen && advanced && len >= 1 && len <= 16 && bytes_taken >= len &&
          window_hits(len)) begin
         hit_seen = 1'b1;
         hit_offset = bytes_taken - len;
      end
      if (last) begin
         r.found = hit_seen;
         r.address = hit_seen ? cfg_base + {32'h0, hit_offset} : 64'h0;
         pending_matches.push_back(r);
         for (int k = 0; k < 16; k++) scan_window[k] = 8'h00;
         bytes_taken = '0;
         hit_seen = 1'b0;
         hit_offset = '0;
      end
   endfunction

   function automatic int unsigned pick_idle_cycles(int mode);
      case (mode)
         IDLE_FULL: return $urandom_range(0, 18);
         IDLE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
         default: return 0;
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycle_count);
      error_count++;
   endtask

   // sender: inputs change on the falling edge
   always @(negedge clock) begin
      region_byte_type head;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (region_bytes_q.size() > 0) begin
            head = region_bytes_q.pop_front();
            req_tdata <= head.data;
            req_tlast <= head.last;
            req_tvalid <= 1'b1;
            req_gap = pick_idle_cycles(req_idle_mode);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: long hold-offs are counted here, short stalls drawn per transaction
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_done < hold_goal) begin
         hold_done++;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_taken) rsp_wait = pick_idle_cycles(rsp_idle_mode);
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // monitor: everything sampled at the rising edge
   always @(posedge clock) begin
      scan_result_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end else if (!reset) begin
         req_taken <= req_tvalid && req_tready;
         rsp_taken <= rsp_tvalid && rsp_tready;
         if (req_tvalid && req_tready) track_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_matches.size() == 0) begin
               report_mismatch("unexpected transaction", rsp_tdata, 64'h0);
            end else begin
               want = pending_matches.pop_front();
               if (rsp_tuser !== want.found)
                  report_mismatch("found", {63'h0, rsp_tuser}, {63'h0, want.found});
               if (rsp_tdata !== want.address)
                  report_mismatch("match_address", rsp_tdata, want.address);
            end
         end
      end
   end

   task automatic csr_write(csr_index_type idx, logic [63:0] value);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_PATTERN_LOW: cfg_pattern_lo = value;
         CSR_PATTERN_HIGH: cfg_pattern_hi = value;
         CSR_MASK_LOW: cfg_mask_lo = value;
         CSR_MASK_HIGH: cfg_mask_hi = value;
         CSR_PATTERN_LENGTH: cfg_length = value[4:0];
         CSR_REGION_BASE: cfg_base = value;
         default: ;
      endcase
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic apply_config(logic [63:0] pat_lo, logic [63:0] pat_hi, logic [63:0] msk_lo,
                               logic [63:0] msk_hi, logic [4:0] len, logic [63:0] base);
      csr_write(CSR_PATTERN_LOW, pat_lo);
      csr_write(CSR_PATTERN_HIGH, pat_hi);
      csr_write(CSR_MASK_LOW, msk_lo);
      csr_write(CSR_MASK_HIGH, msk_hi);
      csr_write(CSR_PATTERN_LENGTH, {59'h0, len});
      csr_write(CSR_REGION_BASE, base);
   endtask

   // sender stops until every result is back and the unit has settled
   task automatic wait_drained();
      while (region_bytes_q.size() != 0 || req_tvalid || pending_matches.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic push_byte(logic [7:0] data, logic last);
      region_byte_type b;
      b.data = data;
      b.last = last;
      region_bytes_q.push_back(b);
   endtask

   // byte that satisfies pattern lane i, masked-off bits random
   function automatic logic [7:0] lane_fit(int i);
      logic [7:0] m;
      m = lane_of(cfg_mask_lo, cfg_mask_hi, i);
      return (lane_of(cfg_pattern_lo, cfg_pattern_hi, i) & m) | (8'($urandom) & ~m);
   endfunction

   task automatic push_region(int unsigned n, int unsigned plants);
      logic [7:0] body [];
      int unsigned len;
      int unsigned at;
      len = cfg_length;
      body = new[n];
      for (int i = 0; i < n; i++) begin
         if (len >= 1 && len <= 16 && $urandom_range(0, 3) == 0)
            body[i] = lane_fit($urandom_range(0, len - 1));
         else
            body[i] = 8'($urandom);
      end
      if (len >= 1 && len <= 16 && n >= len) begin
         for (int p = 0; p < plants; p++) begin
            at = $urandom_range(0, n - len);
            for (int i = 0; i < len; i++) body[at + i] = lane_fit(i);
         end
      end
      for (int i = 0; i < n; i++) push_byte(body[i], i == n - 1);
      random_items += n;
   endtask

   function automatic logic [63:0] random_mask();
      logic [63:0] m;
      int unsigned pick;
      for (int i = 0; i < 8; i++) begin
         pick = $urandom_range(0, 19);
         m[8 * i +: 8] = (pick < 10) ? 8'hff : (pick < 13) ? 8'h00 : 8'($urandom);
      end
      return m;
   endfunction

   initial begin
      int unsigned phase;
      int unsigned start_items;
      int unsigned pick;
      logic [4:0] len;
      logic [63:0] base;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // exact-length final window, address at the very top of the range; then a region shorter than the pattern
      apply_config(64'h0000_0000_7856_3412, 64'h0, '1, '1, 5'd4, 64'hffff_ffff_ffff_fffe);
      push_byte(8'h00, 1'b0);
      push_byte(8'h12, 1'b0);
      push_byte(8'h34, 1'b0);
      push_byte(8'h56, 1'b0);
      push_byte(8'h78, 1'b1);
      push_byte(8'h12, 1'b0);
      push_byte(8'h34, 1'b0);
      push_byte(8'h56, 1'b1);
      wait_drained();
      // zero length never matches, even with every lane a wildcard
      apply_config('1, '1, '0, '0, 5'd0, 64'h0);
      push_byte(8'hff, 1'b1);
      wait_drained();
      // lengths beyond the window never match
      csr_write(CSR_PATTERN_LENGTH, 64'd17);
      push_byte(8'h00, 1'b0);
      push_byte(8'hff, 1'b1);
      wait_drained();
      csr_write(CSR_PATTERN_LENGTH, 64'd31);
      push_byte(8'h55, 1'b1);
      wait_drained();
      // single byte pattern under a partial mask
      apply_config(64'h05, 64'h0, 64'h0f, '1, 5'd1, 64'h1000);
      push_byte(8'hf5, 1'b1);
      push_byte(8'h06, 1'b0);
      push_byte(8'ha5, 1'b1);
      wait_drained();

      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         case (phase)
            0: apply_config('1, '1, '1, '1, 5'd16, '1);
            1: apply_config('0, '0, '0, '0, 5'd1, '0);
            default: begin
               pick = $urandom_range(0, 19);
               len = (pick == 0) ? 5'd0 : (pick == 1) ? 5'($urandom_range(17, 31)) :
                     (pick == 2) ? 5'd16 : 5'($urandom_range(1, 16));
               pick = $urandom_range(0, 3);
               base = (pick == 0) ? 64'h0 : (pick == 1) ? '1 :
                      (pick == 2) ? 64'hffff_ffff_ffff_ff00 | 64'($urandom_range(0, 255)) :
                      {$urandom, $urandom};
               apply_config({$urandom, $urandom}, {$urandom, $urandom}, random_mask(),
                            random_mask(), len, base);
            end
         endcase
         req_idle_mode = (phase % 3 == 0) ? IDLE_FULL : (phase % 3 == 1) ? IDLE_SPARSE : IDLE_NONE;
         rsp_idle_mode = ((phase / 3) % 3 == 0) ? IDLE_SPARSE :
                         ((phase / 3) % 3 == 1) ? IDLE_NONE : IDLE_FULL;
         start_items = random_items;
         if (phase == 2) begin
            // receiver holds off while short regions keep coming, so the queue backs up
            req_idle_mode = IDLE_NONE;
            hold_goal += 300;
            while (random_items - start_items < PHASE_ITEMS)
               push_region($urandom_range(1, 3), $urandom_range(0, 1));
         end else begin
            while (random_items - start_items < PHASE_ITEMS) begin
               pick = $urandom_range(0, 9);
               if (pick < 2)
                  push_region($urandom_range(1, (cfg_length > 1) ? cfg_length : 2),
                              $urandom_range(0, 1));
               else if (pick < 4)
                  push_region($urandom_range(1, 24), 0);
               else
                  push_region($urandom_range(1, cfg_length + 24), $urandom_range(1, 2));
            end
         end
         wait_drained();
         phase++;
      end

      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* masked_byte_pattern_scan_unit.f */
rtl/mbps_pkg.sv
rtl/mbps_front.sv
rtl/mbps_queue.sv
rtl/mbps_back.sv
rtl/masked_byte_pattern_scan_unit.sv
sim/tb_masked_byte_pattern_scan_unit.sv
